// ===== design/minimum_spanning_tree_prim_defines.svh =====
// Assertion macros for the spanning tree block
`ifndef MINIMUM_SPANNING_TREE_PRIM_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_PRIM_DEFINES_SVH

// same-cycle implication
`define MSTP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define MSTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/mstp_pkg.sv =====
package mstp_pkg;

   localparam int MAX_NODES   = 16;
   localparam int MIN_NODES   = 2;
   localparam int NODE_BITS   = $clog2(MAX_NODES);
   localparam int ADDR_BITS   = 2 * NODE_BITS;
   localparam int DEPTH       = MAX_NODES * MAX_NODES;
   localparam int WEIGHT_BITS = 16;
   localparam int COUNT_BITS  = NODE_BITS + 1;

   localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = COUNT_BITS'(MAX_NODES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RELAX,
      ST_SELECT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                   en;
      logic [ADDR_BITS-1:0]   addr;
      logic                   present;
      logic [WEIGHT_BITS-1:0] weight;
   } store_wr_type;

   typedef struct packed {
      logic                   present;
      logic [WEIGHT_BITS-1:0] weight;
   } store_rd_type;

endpackage

// ===== design/mstp_store.sv =====
module mstp_store (
   input  logic                          clock,
   input  logic                          reset,
   input  mstp_pkg::store_wr_type        wr,
   input  logic                          rd_en,
   input  logic [mstp_pkg::ADDR_BITS-1:0] rd_addr,
   input  logic                          clear,
   output mstp_pkg::store_rd_type        rd
);

   logic [mstp_pkg::WEIGHT_BITS-1:0] mem [mstp_pkg::DEPTH];
   logic [mstp_pkg::DEPTH-1:0]       present_ff;
   logic [mstp_pkg::WEIGHT_BITS-1:0] rd_weight_ff;
   logic                             rd_present_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.weight;
      end
      if (rd_en) begin
         rd_weight_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         present_ff <= '0;
      end else if (wr.en) begin
         present_ff[wr.addr] <= wr.present;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_present_ff <= present_ff[rd_addr];
      end
   end

   assign rd.present = rd_present_ff;
   assign rd.weight  = rd_weight_ff;

endmodule

// ===== design/minimum_spanning_tree_prim.sv =====
// Load: one matrix word per cycle while idle, back to back; no result unless last is set.
// Run after a last word: each round relaxes the picked node's row on the store read port,
// searches for the minimum key on the shared comparator and emits one result, which
// waits while the result output stalls; input waits until the run is over.
// Reset: synchronous; presence bits clear, node_count returns to 16.
`include "minimum_spanning_tree_prim_defines.svh"

module minimum_spanning_tree_prim (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [3:0]                        req_from_node,
   input  logic [3:0]                        req_to_node,
   input  logic                              req_edge_present,
   input  logic [15:0]                       req_weight,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [3:0]                        rsp_parent_node,
   output logic [3:0]                        rsp_child_node,
   output logic [15:0]                       rsp_edge_weight,
   output logic                              rsp_disconnected,
   output logic                              rsp_last_result,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [4:0]                        csr_node_count
);

   localparam int NB = mstp_pkg::NODE_BITS;
   localparam int CB = mstp_pkg::COUNT_BITS;
   localparam int WB = mstp_pkg::WEIGHT_BITS;
   localparam int MN = mstp_pkg::MAX_NODES;

   mstp_pkg::state_type state_ff, state_in;

   logic [CB-1:0] node_count_ff;
   logic [CB-1:0] n_ff, n_in, n_sat;
   logic [CB-1:0] idx_ff, idx_in;
   logic [CB-1:0] round_ff, round_in;
   logic [NB-1:0] pick_ff, pick_in;
   logic          found_ff, found_in;
   logic [NB-1:0] sel_node_ff, sel_node_in;
   logic [NB-1:0] sel_par_ff, sel_par_in;
   logic [WB-1:0] sel_key_ff, sel_key_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [NB-1:0] rd_idx_ff, rd_idx_in;
   logic [MN-1:0] visited_ff, visited_in;
   logic [MN-1:0] reached_ff, reached_in;
   logic [WB-1:0] key_ff [MN];
   logic [NB-1:0] par_ff [MN];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [NB-1:0] rsp_parent_ff, rsp_parent_in;
   logic [NB-1:0] rsp_child_ff, rsp_child_in;
   logic [WB-1:0] rsp_weight_ff, rsp_weight_in;
   logic          rsp_disc_ff, rsp_disc_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          load_rsp;

   mstp_pkg::store_wr_type st_wr;
   mstp_pkg::store_rd_type st_rd;
   logic                   st_rd_en;
   logic [mstp_pkg::ADDR_BITS-1:0] st_rd_addr;
   logic                   st_clear;

   logic [WB-1:0] cmp_a, cmp_b;
   logic          cmp_lt;
   logic [NB-1:0] sel_i;
   logic          relax_upd;
   logic          sel_take;

   mstp_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (st_wr),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .clear   (st_clear),
      .rd      (st_rd)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == mstp_pkg::ST_IDLE);

   always_comb begin
      if (node_count_ff > CB'(MN)) begin
         n_sat = CB'(MN);
      end else if (node_count_ff < CB'(mstp_pkg::MIN_NODES)) begin
         n_sat = CB'(mstp_pkg::MIN_NODES);
      end else begin
         n_sat = node_count_ff;
      end
   end

   // shared comparator: relaxation in RELAX, minimum search in SELECT
   assign sel_i = idx_ff[NB-1:0];

   always_comb begin
      if (state_ff == mstp_pkg::ST_SELECT) begin
         cmp_a = key_ff[sel_i];
         cmp_b = sel_key_ff;
      end else begin
         cmp_a = st_rd.weight;
         cmp_b = key_ff[rd_idx_ff];
      end
   end

   assign cmp_lt    = cmp_a < cmp_b;
   assign relax_upd = rd_vld_ff && !visited_ff[rd_idx_ff] && st_rd.present &&
                      (!reached_ff[rd_idx_ff] || cmp_lt);
   assign sel_take  = (state_ff == mstp_pkg::ST_SELECT) && !visited_ff[sel_i] &&
                      reached_ff[sel_i] && (!found_ff || cmp_lt);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      round_in      = round_ff;
      pick_in       = pick_ff;
      found_in      = found_ff;
      sel_node_in   = sel_node_ff;
      sel_par_in    = sel_par_ff;
      sel_key_in    = sel_key_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = idx_ff[NB-1:0];
      visited_in    = visited_ff;
      reached_in    = reached_ff;
      st_wr.en      = 1'b0;
      st_wr.addr    = {req_from_node, req_to_node};
      st_wr.present = req_edge_present;
      st_wr.weight  = req_weight;
      st_rd_en      = 1'b0;
      st_rd_addr    = {pick_ff, idx_ff[NB-1:0]};
      st_clear      = 1'b0;
      load_rsp      = 1'b0;
      rsp_parent_in = sel_par_ff;
      rsp_child_in  = sel_node_ff;
      rsp_weight_in = sel_key_ff;
      rsp_disc_in   = 1'b0;
      rsp_last_in   = 1'b0;

      if (relax_upd) begin
         reached_in[rd_idx_ff] = 1'b1;
      end

      case (state_ff)
         mstp_pkg::ST_IDLE: begin
            st_wr.en = req_valid;
            if (req_valid && req_last) begin
               n_in       = n_sat;
               visited_in = MN'(1);
               reached_in = '0;
               pick_in    = '0;
               idx_in     = CB'(1);
               round_in   = CB'(1);
               state_in   = mstp_pkg::ST_RELAX;
            end
         end
         mstp_pkg::ST_RELAX: begin
            if (idx_ff < n_ff) begin
               st_rd_en  = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + CB'(1);
            end else if (!rd_vld_ff) begin
               idx_in   = CB'(1);
               found_in = 1'b0;
               state_in = mstp_pkg::ST_SELECT;
            end
         end
         mstp_pkg::ST_SELECT: begin
            if (sel_take) begin
               found_in    = 1'b1;
               sel_node_in = sel_i;
               sel_key_in  = cmp_a;
               sel_par_in  = par_ff[sel_i];
            end
            if (idx_ff == n_ff - CB'(1)) begin
               state_in = mstp_pkg::ST_EMIT;
            end else begin
               idx_in = idx_ff + CB'(1);
            end
         end
         mstp_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               if (!found_ff) begin
                  rsp_parent_in = '0;
                  rsp_child_in  = '0;
                  rsp_weight_in = '0;
                  rsp_disc_in   = 1'b1;
                  rsp_last_in   = 1'b1;
                  st_clear      = 1'b1;
                  state_in      = mstp_pkg::ST_IDLE;
               end else begin
                  rsp_last_in = (round_ff == n_ff - CB'(1));
                  visited_in[sel_node_ff] = 1'b1;
                  pick_in = sel_node_ff;
                  if (round_ff == n_ff - CB'(1)) begin
                     st_clear = 1'b1;
                     state_in = mstp_pkg::ST_IDLE;
                  end else begin
                     round_in = round_ff + CB'(1);
                     idx_in   = CB'(1);
                     state_in = mstp_pkg::ST_RELAX;
                  end
               end
            end
         end
         default: begin
            state_in = mstp_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mstp_pkg::ST_IDLE;
         node_count_ff <= mstp_pkg::NODE_COUNT_RESET;
         rd_vld_ff     <= 1'b0;
         visited_ff    <= '0;
         reached_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         visited_ff <= visited_in;
         reached_ff <= reached_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            node_count_ff <= csr_node_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      round_ff    <= round_in;
      pick_ff     <= pick_in;
      found_ff    <= found_in;
      sel_node_ff <= sel_node_in;
      sel_par_ff  <= sel_par_in;
      sel_key_ff  <= sel_key_in;
      rd_idx_ff   <= rd_idx_in;
      if (relax_upd) begin
         key_ff[rd_idx_ff] <= st_rd.weight;
         par_ff[rd_idx_ff] <= pick_ff;
      end
      if (load_rsp) begin
         rsp_parent_ff <= rsp_parent_in;
         rsp_child_ff  <= rsp_child_in;
         rsp_weight_ff <= rsp_weight_in;
         rsp_disc_ff   <= rsp_disc_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parent_node  = rsp_parent_ff;
   assign rsp_child_node   = rsp_child_ff;
   assign rsp_edge_weight  = rsp_weight_ff;
   assign rsp_disconnected = rsp_disc_ff;
   assign rsp_last_result  = rsp_last_ff;

   `MSTP_ASSERT_NOW(a_root_visited, clock, reset, state_ff != mstp_pkg::ST_IDLE, visited_ff[0])
   `MSTP_ASSERT_NOW(a_read_in_relax, clock, reset, rd_vld_ff, state_ff == mstp_pkg::ST_RELAX)
   `MSTP_ASSERT_NOW(a_no_overwrite, clock, reset, load_rsp, !rsp_valid_ff || rsp_ready)
   `MSTP_ASSERT_NEXT(a_last_ends_run, clock, reset, load_rsp && rsp_last_in, state_ff == mstp_pkg::ST_IDLE)

endmodule
